/* hdl/sbda_pkg.sv */
// Shared constants and control/status structs for the signed binary to
// decimal ASCII converter. No dependencies.
`default_nettype none

package sbda_pkg;

  // Width of the signed input value
  localparam int VALUE_BITS = 32;

  // Decimal digits needed for the largest magnitude, 2**(VALUE_BITS-1).
  // 1233/4096 approximates log10(2) closely enough for 8 to 64 bits.
  localparam int DEC_DIGITS = (((VALUE_BITS - 1) * 1233) >> 12) + 1;
  localparam int BCD_BITS   = 4 * DEC_DIGITS;

  localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);
  localparam int DIG_CNT_W = $clog2(DEC_DIGITS + 1);

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture magnitude and sign, clear BCD
    logic conv_step;   // one shift-and-add-3 step
    logic digit_shift; // drop the top digit
    logic sel_sign;    // output character is the minus sign
  } sbda_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bit_last;    // final conversion step
    logic top_zero;    // top BCD digit is zero
    logic digit_one;   // one digit left
    logic negative;    // captured value was negative
  } sbda_sts_t;

endpackage

`default_nettype wire

/* hdl/sbda_datapath.sv */
// Datapath: magnitude register, shift-and-add-3 BCD converter, digit
// and bit counters, and character selection. Depends on sbda_pkg.
`default_nettype none

module sbda_datapath (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire logic signed [sbda_pkg::VALUE_BITS-1:0] in_value,
  input  wire sbda_pkg::sbda_cmd_t         cmd,
  output sbda_pkg::sbda_sts_t              sts,
  output logic [7:0]                       out_character
);
  import sbda_pkg::*;

  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [BCD_BITS-1:0]   bcd_r, bcd_nxt;
  logic [BCD_BITS-1:0]   bcd_adj;
  logic [BIT_CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0]  dig_cnt_r, dig_cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic [3:0]            top_digit;

  assign top_digit = bcd_r[BCD_BITS-1 -: 4];

  // Add 3 to every digit of 5 or more ahead of the shift
  always_comb begin
    for (int d = 0; d < DEC_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  always_comb begin
    mag_nxt     = mag_r;
    bcd_nxt     = bcd_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    neg_nxt     = neg_r;
    if (cmd.load) begin
      neg_nxt     = in_value[VALUE_BITS-1];
      // Most negative value negates to itself, which is its true magnitude
      mag_nxt     = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;
      bcd_nxt     = '0;
      bit_cnt_nxt = BIT_CNT_W'(VALUE_BITS);
      dig_cnt_nxt = DIG_CNT_W'(DEC_DIGITS);
    end else if (cmd.conv_step) begin
      bcd_nxt     = {bcd_adj[BCD_BITS-2:0], mag_r[VALUE_BITS-1]};
      mag_nxt     = {mag_r[VALUE_BITS-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r - 1'b1;
    end else if (cmd.digit_shift) begin
      bcd_nxt     = {bcd_r[BCD_BITS-5:0], 4'd0};
      dig_cnt_nxt = dig_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r <= '0;
      dig_cnt_r <= '0;
    end else begin
      bit_cnt_r <= bit_cnt_nxt;
      dig_cnt_r <= dig_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

  assign sts.bit_last  = (bit_cnt_r == BIT_CNT_W'(1));
  assign sts.top_zero  = (top_digit == 4'd0);
  assign sts.digit_one = (dig_cnt_r == DIG_CNT_W'(1));
  assign sts.negative  = neg_r;

  assign out_character = cmd.sel_sign ? ASCII_MINUS : (ASCII_ZERO + {4'd0, top_digit});

endmodule

`default_nettype wire

/* hdl/sbda_ctrl.sv */
// Controller: one-hot state machine that sequences capture, conversion,
// leading-zero skip, sign and digit beats. Depends on sbda_pkg.
`default_nettype none

module sbda_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  output logic                out_valid,
  output logic                out_last,
  input  wire                 out_stall,
  input  wire sbda_pkg::sbda_sts_t sts,
  output sbda_pkg::sbda_cmd_t cmd
);
  import sbda_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SKIP = 5'b00100,
    S_SIGN = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CONV;
      end
      S_CONV: begin
        if (sts.bit_last) state_nxt = S_SKIP;
      end
      S_SKIP: begin
        if (!sts.top_zero || sts.digit_one) begin
          state_nxt = sts.negative ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (!out_stall) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall && sts.digit_one) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_SIGN) || (state_r == S_EMIT);
  assign out_last  = (state_r == S_EMIT) && sts.digit_one;

  assign cmd.load        = (state_r == S_IDLE) && in_valid;
  assign cmd.conv_step   = (state_r == S_CONV);
  // Drop leading zeros, and advance after each digit beat but the last
  assign cmd.digit_shift = ((state_r == S_SKIP) && sts.top_zero && !sts.digit_one) ||
                           ((state_r == S_EMIT) && !out_stall && !sts.digit_one);
  assign cmd.sel_sign    = (state_r == S_SIGN);

endmodule

`default_nettype wire

/* hdl/signed_binary_to_decimal_ascii_top.sv */
// Signed binary to decimal ASCII converter, top level. One number at a time:
// accept, VALUE_BITS shift-and-add-3 steps, a skip of the leading zero digits,
// then one beat per character (sign, then digits); an output stall holds the
// beat. The BCD shift loop sets the bulk of the time per item. Synchronous
// active-low reset returns to idle.
`default_nettype none

module signed_binary_to_decimal_ascii_top (
  input  wire                                         clk,
  input  wire                                         rst_n,
  input  wire                                         in_valid,
  output logic                                        in_stall,
  input  wire logic signed [sbda_pkg::VALUE_BITS-1:0] in_value,
  output logic                                        out_valid,
  input  wire                                         out_stall,
  output logic [7:0]                                  out_character,
  output logic                                        out_last
);
  import sbda_pkg::*;

  sbda_cmd_t cmd;
  sbda_sts_t sts;

  sbda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_last  (out_last),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sbda_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_character (out_character)
  );

`ifndef SYNTH
  // Never take an input while a result is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input ready while output valid");

  // A fresh item produces no beat in the cycle after capture
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && !out_valid))
    else $error("accept not followed by conversion");

  // After the final character is taken the block returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && !out_stall) |=> (!out_valid && !in_stall))
    else $error("no return to idle after last beat");

  // The sign is never flagged as the last character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_character == ASCII_MINUS) |-> !out_last)
    else $error("minus sign flagged last");
`endif

endmodule

`default_nettype wire
